/* src/pcmr_pkg.sv */
// shared types, constants and a helper function for the pixel channel mask repacker
package pcmr_pkg;

  // pixel word geometry
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned NUM_CH = 4;
  localparam int unsigned POS_W  = $clog2(PIX_W);
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // input and result beats
  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_out;
  } pix_out_t;

  // register map, one 32-bit register every four bytes
  typedef enum logic [2:0] {
    REG_SRC_RED   = 3'd0,
    REG_SRC_GREEN = 3'd1,
    REG_SRC_BLUE  = 3'd2,
    REG_SRC_ALPHA = 3'd3,
    REG_DST_RED   = 3'd4,
    REG_DST_GREEN = 3'd5,
    REG_DST_BLUE  = 3'd6,
    REG_DST_ALPHA = 3'd7
  } reg_idx_t;

  // channel order inside the mask arrays
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] mask_set_t;

  // reset layout: 8 bits per channel, red lowest
  localparam mask_set_t MASK_RST = {
    32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF
  };

  // packed-value index of each mask bit
  typedef logic [PIX_W-1:0][POS_W-1:0] pos_vec_t;

  // for every bit position, the number of set mask bits below it
  function automatic pos_vec_t prefix_pos(input logic [PIX_W-1:0] mask);
    pos_vec_t         pos;
    logic [PIX_W-1:0] below;
    for (int i = 0; i < PIX_W; i++) begin
      below  = mask & ((PIX_W'(1) << i) - PIX_W'(1));
      pos[i] = POS_W'($countones(below));
    end
    return pos;
  endfunction

endpackage

/* src/pixel_channel_mask_repack.sv */
// top level of the pixel channel mask repacker: register file and three-stage pipeline
//
// Unstalled, converts one 32-bit pixel per cycle between two bitmask channel layouts.
// For red, green, blue and alpha the bits picked by the source mask are
// packed lowest first and then spread, lowest first, over the bits of the
// destination mask; the four channels are ORed into the result. Extra source
// bits are dropped, unfilled destination bits read zero, overlapping masks OR
// together. A pixel passes three register stages (mask prefix counts, bit
// gather, bit scatter) before it is offered at the output, and while the
// output does not stall a new pixel is accepted every cycle; each stage holds
// its beat only while the stage after it is full and stalled. Masks sit at
// byte addresses 0x00 to 0x1C (source red, green, blue, alpha, then
// destination red, green, blue, alpha), reset to an 8-bit per channel layout
// with red in the low byte, and must only be changed while no pixel is in
// flight.
module pixel_channel_mask_repack
  import pcmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              in_valid,
  output logic              in_ready,
  input  pix_in_t           in_data,
  // pixel output
  output logic              out_valid,
  input  logic              out_ready,
  output pix_out_t          out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // mask registers
  mask_set_t src_mask_r, src_mask_nxt;
  mask_set_t dst_mask_r, dst_mask_nxt;
  logic      cfg_wr;
  reg_idx_t  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  // register write decode
  always_comb begin
    src_mask_nxt = src_mask_r;
    dst_mask_nxt = dst_mask_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_RED:   src_mask_nxt[CH_RED]   = pwdata;
        REG_SRC_GREEN: src_mask_nxt[CH_GREEN] = pwdata;
        REG_SRC_BLUE:  src_mask_nxt[CH_BLUE]  = pwdata;
        REG_SRC_ALPHA: src_mask_nxt[CH_ALPHA] = pwdata;
        REG_DST_RED:   dst_mask_nxt[CH_RED]   = pwdata;
        REG_DST_GREEN: dst_mask_nxt[CH_GREEN] = pwdata;
        REG_DST_BLUE:  dst_mask_nxt[CH_BLUE]  = pwdata;
        REG_DST_ALPHA: dst_mask_nxt[CH_ALPHA] = pwdata;
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (cfg_idx)
      REG_SRC_RED:   prdata = src_mask_r[CH_RED];
      REG_SRC_GREEN: prdata = src_mask_r[CH_GREEN];
      REG_SRC_BLUE:  prdata = src_mask_r[CH_BLUE];
      REG_SRC_ALPHA: prdata = src_mask_r[CH_ALPHA];
      REG_DST_RED:   prdata = dst_mask_r[CH_RED];
      REG_DST_GREEN: prdata = dst_mask_r[CH_GREEN];
      REG_DST_BLUE:  prdata = dst_mask_r[CH_BLUE];
      REG_DST_ALPHA: prdata = dst_mask_r[CH_ALPHA];
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_mask_r <= MASK_RST;
      dst_mask_r <= MASK_RST;
    end else begin
      src_mask_r <= src_mask_nxt;
      dst_mask_r <= dst_mask_nxt;
    end
  end

  // pipeline stage registers
  logic                         a_vld_r, b_vld_r, c_vld_r;
  logic                         a_rdy, b_rdy, c_rdy;
  logic [PIX_W-1:0]             a_pix_r;
  logic                         a_last_r, b_last_r, c_last_r;
  pos_vec_t [NUM_CH-1:0]        a_spos_r, a_spos_nxt;
  pos_vec_t [NUM_CH-1:0]        b_dpos_r, b_dpos_nxt;
  logic [NUM_CH-1:0][PIX_W-1:0] b_pack_r, b_pack_nxt;
  logic [PIX_W-1:0]             c_pix_r, c_pix_nxt;

  // a stage moves when it is empty or the next one takes its beat
  assign c_rdy    = !c_vld_r || out_ready;
  assign b_rdy    = !b_vld_r || c_rdy;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  // stage a: packed index of every source mask bit
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      a_spos_nxt[c] = prefix_pos(src_mask_r[c]);
    end
  end

  // stage b: gather source bits into packed channel values, index destination bits
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      b_dpos_nxt[c] = prefix_pos(dst_mask_r[c]);
      for (int p = 0; p < PIX_W; p++) begin
        b_pack_nxt[c][p] = 1'b0;
        for (int i = 0; i < PIX_W; i++) begin
          if (src_mask_r[c][i] && (a_spos_r[c][i] == POS_W'(p))) begin
            b_pack_nxt[c][p] = b_pack_nxt[c][p] | a_pix_r[i];
          end
        end
      end
    end
  end

  // stage c: scatter packed values into destination positions and merge channels
  always_comb begin
    c_pix_nxt = '0;
    for (int i = 0; i < PIX_W; i++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        c_pix_nxt[i] = c_pix_nxt[i] | (dst_mask_r[c][i] & b_pack_r[c][b_dpos_r[c][i]]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= in_valid;
      if (b_rdy) b_vld_r <= a_vld_r;
      if (c_rdy) c_vld_r <= b_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_pix_r  <= in_data.pixel_in;
      a_last_r <= in_data.last_pixel;
      a_spos_r <= a_spos_nxt;
    end
    if (b_rdy) begin
      b_pack_r <= b_pack_nxt;
      b_dpos_r <= b_dpos_nxt;
      b_last_r <= a_last_r;
    end
    if (c_rdy) begin
      c_pix_r  <= c_pix_nxt;
      c_last_r <= b_last_r;
    end
  end

  assign out_valid          = c_vld_r;
  assign out_data.pixel_out = c_pix_r;
  assign out_data.last_out  = c_last_r;

endmodule

/* tb/sv/tb_pixel_channel_mask_repack.sv */
// testbench for the pixel channel mask repacker: directed layouts, random masks, scoreboard
`timescale 1ns / 100ps

module tb_pixel_channel_mask_repack
  import pcmr_pkg::*;
;

  // full register image: source and destination mask per channel
  typedef struct packed {
    mask_set_t src;
    mask_set_t dst;
  } layout_t;

  typedef enum int {
    LAY_RESET,
    LAY_SHRINK,
    LAY_GROW,
    LAY_SRC_SHARE,
    LAY_DST_SHARE,
    LAY_EMPTY,
    LAY_FULL,
    LAY_SWAP,
    LAY_SCATTER
  } layout_sel_t;

  typedef struct {
    layout_sel_t      layout;
    logic [PIX_W-1:0] pixel;
    logic             last;
    bit               typed;
    logic [PIX_W-1:0] pixel_exp;
  } stim_row_t;

  localparam int N_DIRECTED    = 22;
  localparam int N_PHASES      = 8;
  localparam int PHASE_PIXELS  = 190;
  localparam int SETTLE_CYCLES = 6;

  // directed rows: reset layout, dropped and missing bits, shared masks,
  // empty and full masks, then layouts left to the predictor
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{LAY_RESET,     32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{LAY_RESET,     32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{LAY_RESET,     32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678},
    '{LAY_RESET,     32'h8000_0001, 1'b1, 1'b1, 32'h8000_0001},
    '{LAY_SHRINK,    32'h0000_ABCD, 1'b0, 1'b1, 32'h0000_000D},
    '{LAY_SHRINK,    32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_000F},
    '{LAY_GROW,      32'hFFFF_FFF5, 1'b0, 1'b1, 32'h0005_0000},
    '{LAY_GROW,      32'h0000_000F, 1'b1, 1'b1, 32'h000F_0000},
    '{LAY_SRC_SHARE, 32'h0000_005A, 1'b0, 1'b1, 32'h0000_5A5A},
    '{LAY_SRC_SHARE, 32'hFFFF_FF00, 1'b0, 1'b1, 32'h0000_0000},
    '{LAY_DST_SHARE, 32'h0000_0F30, 1'b0, 1'b1, 32'h0000_003F},
    '{LAY_DST_SHARE, 32'h0000_FFFF, 1'b1, 1'b1, 32'h0000_00FF},
    '{LAY_EMPTY,     32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{LAY_EMPTY,     32'hA5A5_A5A5, 1'b0, 1'b1, 32'h0000_0000},
    '{LAY_FULL,      32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{LAY_FULL,      32'h5A5A_A5A5, 1'b1, 1'b1, 32'h5A5A_A5A5},
    '{LAY_FULL,      32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{LAY_SWAP,      32'h1122_3344, 1'b0, 1'b0, 32'h0},
    '{LAY_SWAP,      32'hFF00_0000, 1'b1, 1'b0, 32'h0},
    '{LAY_SCATTER,   32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0},
    '{LAY_SCATTER,   32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{LAY_SCATTER,   32'h8000_0000, 1'b0, 1'b0, 32'h0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pix_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pix_out_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  layout_t           active_layout;
  pix_out_t          pending_pixels [$];
  int                mismatch_count = 0;
  bit                calm = 1'b0;
  int                stall_left = 0;

  pixel_channel_mask_repack uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // gather each channel through its source mask, scatter through its destination mask
  function automatic logic [PIX_W-1:0] repack_pixel(input logic [PIX_W-1:0] px,
                                                    input layout_t l);
    logic [PIX_W-1:0] word;
    logic [PIX_W-1:0] packed_val;
    int               pos;
    word = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      packed_val = '0;
      pos = 0;
      for (int i = 0; i < PIX_W; i++) begin
        if (l.src[ch][i]) begin
          packed_val[pos] = px[i];
          pos++;
        end
      end
      pos = 0;
      for (int i = 0; i < PIX_W; i++) begin
        if (l.dst[ch][i]) begin
          word[i] = word[i] | packed_val[pos];
          pos++;
        end
      end
    end
    return word;
  endfunction

  function automatic layout_t layout_of(input layout_sel_t sel);
    layout_t l;
    l = '0;
    unique case (sel)
      LAY_RESET: begin
        l.src = MASK_RST;
        l.dst = MASK_RST;
      end
      LAY_SHRINK: begin
        l.src[CH_RED] = 32'h0000_FFFF;
        l.dst[CH_RED] = 32'h0000_000F;
      end
      LAY_GROW: begin
        l.src[CH_RED] = 32'h0000_000F;
        l.dst[CH_RED] = 32'hFFFF_0000;
      end
      LAY_SRC_SHARE: begin
        l.src[CH_RED]   = 32'h0000_00FF;
        l.src[CH_GREEN] = 32'h0000_00FF;
        l.dst[CH_RED]   = 32'h0000_00FF;
        l.dst[CH_GREEN] = 32'h0000_FF00;
      end
      LAY_DST_SHARE: begin
        l.src[CH_RED]   = 32'h0000_00FF;
        l.src[CH_GREEN] = 32'h0000_FF00;
        l.dst[CH_RED]   = 32'h0000_00FF;
        l.dst[CH_GREEN] = 32'h0000_00FF;
      end
      LAY_FULL: begin
        l.src = '1;
        l.dst = '1;
      end
      LAY_SWAP: begin
        l.src = MASK_RST;
        l.dst[CH_RED]   = 32'h00FF_0000;
        l.dst[CH_GREEN] = 32'h0000_FF00;
        l.dst[CH_BLUE]  = 32'h0000_00FF;
        l.dst[CH_ALPHA] = 32'hFF00_0000;
      end
      LAY_SCATTER: begin
        l.src[CH_RED]   = 32'h8000_0001;
        l.src[CH_GREEN] = 32'h0F0F_0F0F;
        l.src[CH_BLUE]  = 32'h1248_0000;
        l.src[CH_ALPHA] = 32'h0000_7000;
        l.dst[CH_RED]   = 32'h0001_8000;
        l.dst[CH_GREEN] = 32'hF000_0000;
        l.dst[CH_BLUE]  = 32'hFFFF_FFFF;
        l.dst[CH_ALPHA] = 32'h0000_0006;
      end
      default: l = '0;
    endcase
    return l;
  endfunction

  // mixes realistic contiguous fields with empty, full and random masks
  function automatic logic [PIX_W-1:0] random_mask();
    logic [63:0] run;
    int          w;
    int          s;
    unique case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return $urandom & $urandom & $urandom;
      4: return $urandom | $urandom;
      default: begin
        w = $urandom_range(1, 32);
        s = $urandom_range(0, 32 - w);
        run = ((64'd1 << w) - 64'd1) << s;
        return run[PIX_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    unique case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return PIX_W'(1) << $urandom_range(0, 31);
      3: return ~(PIX_W'(1) << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // one register write: setup, access, then idle
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // hold off new pixels until every converted pixel has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_layout(input layout_t l);
    drain_results();
    for (int ch = 0; ch < NUM_CH; ch++) begin
      write_reg(reg_idx_t'(REG_SRC_RED + ch), l.src[ch]);
      write_reg(reg_idx_t'(REG_DST_RED + ch), l.dst[ch]);
    end
    active_layout = l;
  endtask

  // drive one pixel beat and log its expected conversion once accepted
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic last,
                            input bit typed, input logic [PIX_W-1:0] px_exp);
    pix_out_t conv;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.pixel_in   <= px;
    in_data.last_pixel <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    conv.pixel_out = typed ? px_exp : repack_pixel(px, active_layout);
    conv.last_out  = last;
    pending_pixels.push_back(conv);
  endtask

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= ($urandom_range(0, 2) != 0);
      stall_left <= $urandom_range(1, 19);
    end
  end

  // compare each output beat against the oldest expectation
  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat pixel_out=%h", out_data.pixel_out));
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_out !== want.pixel_out)
          flag_mismatch($sformatf("pixel_out %h, expected %h",
                                  out_data.pixel_out, want.pixel_out));
        if (out_data.last_out !== want.last_out)
          flag_mismatch($sformatf("last_out %b, expected %b",
                                  out_data.last_out, want.last_out));
      end
    end
  end

  // main sequence
  initial begin
    layout_t     l;
    layout_sel_t cur_sel;
    active_layout = layout_of(LAY_RESET);
    cur_sel = LAY_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].layout != cur_sel) begin
        cur_sel = directed_rows[r].layout;
        apply_layout(layout_of(cur_sel));
      end
      send_pixel(directed_rows[r].pixel, directed_rows[r].last,
                 directed_rows[r].typed, directed_rows[r].pixel_exp);
    end

    // random layouts, each followed by a stream of pixels
    for (int phase = 0; phase < N_PHASES; phase++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        l.src[ch] = random_mask();
        l.dst[ch] = random_mask();
      end
      apply_layout(l);
      calm = (phase == N_PHASES - 1);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        if (phase == 2 && k == PHASE_PIXELS / 2) drain_results();
        send_pixel(random_pixel(), ($urandom_range(0, 15) == 0), 1'b0, '0);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
